// ===== sv/rc_ode_pkg.sv =====
package rc_ode_pkg;

  // Fixed-point format of every state, coefficient and sample
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DW        = 32;   // signed data width
  localparam int unsigned CW        = 31;   // unsigned coefficient width
  localparam int unsigned IDX_W     = 3;    // configuration register index width
  localparam int unsigned STEP_W    = 4;    // sequencer step counter width
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(8);

  // Coefficient reset values
  localparam logic [CW-1:0] R3_RST = CW'(458752);
  localparam logic [CW-1:0] G_RST  = CW'(5461);
  localparam logic [CW-1:0] K1_RST = CW'(2185);
  localparam logic [CW-1:0] K2_RST = CW'(4369);
  localparam logic [CW-1:0] K3_RST = CW'(3277);

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_SERIES_RES = 3'd0,
    CFG_LOOP_COND  = 3'd1,
    CFG_STEP_C1    = 3'd2,
    CFG_STEP_C2    = 3'd3,
    CFG_STEP_C3    = 3'd4
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_R3_X0,
    MUL_K2_X0,
    MUL_G_SUM,
    MUL_K1_A,
    MUL_K3_T
  } mul_op_e;

  // Destination of the scaled, saturated product
  typedef enum logic [2:0] {
    PD_NONE,
    PD_DROP,
    PD_D0,
    PD_D1,
    PD_D2,
    PD_A
  } prod_dst_e;

  // Adder operations
  typedef enum logic [2:0] {
    ADD_NONE,
    ADD_SUM,
    ADD_T,
    ADD_UPD0,
    ADD_UPD1,
    ADD_UPD2
  } add_op_e;

  // Control word from the sequencer to the datapath
  typedef struct packed {
    mul_op_e   mul_op;
    prod_dst_e prod_dst;
    add_op_e   add_op;
    logic      pass;     // 0: predictor pass, 1: corrector pass
    logic      start;    // transaction accepted this cycle
    logic      finish;   // result loaded into the output register
  } ctrl_t;

  typedef struct packed {
    logic signed [DW-1:0] val;
    logic                 ovf;
  } sat_t;

  // Clamp to the signed 32-bit range, flagging any clamp
  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r.val = 32'sh7FFF_FFFF;
      r.ovf = 1'b1;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r.val = 32'sh8000_0000;
      r.ovf = 1'b1;
    end else begin
      r.val = v[DW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/rc_ode_alu.sv =====
module rc_ode_alu (
  input  logic                           clk_i,
  input  logic [rc_ode_pkg::CW-1:0]      mul_coef_i,
  input  logic signed [rc_ode_pkg::DW-1:0] mul_val_i,
  input  logic signed [rc_ode_pkg::DW-1:0] add_a_i [4],
  input  logic [3:0]                     add_neg_i,
  output rc_ode_pkg::sat_t               prod_o,
  output rc_ode_pkg::sat_t               add_o
);
  import rc_ode_pkg::*;

  logic signed [63:0] prod_q;
  logic signed [63:0] prod_d;
  logic signed [63:0] prod_shift;
  logic signed [DW+2:0] term [4];
  logic signed [DW+2:0] add_sum;

  // Multiplier stage, product registered
  assign prod_d = 64'($signed({1'b0, mul_coef_i})) * 64'(mul_val_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // Floor scaling of the registered product, then clamp
  assign prod_shift = prod_q >>> FRAC_BITS;
  assign prod_o     = sat32(prod_shift);

  // Four-input adder with per-operand negation, then clamp
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      term[k] = add_neg_i[k] ? -(35'(add_a_i[k])) : 35'(add_a_i[k]);
    end
    add_sum = term[0] + term[1] + term[2] + term[3];
  end

  assign add_o = sat32(64'(add_sum));

endmodule

// ===== sv/rc_ode_seq.sv =====
module rc_ode_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_free_i,
  output logic              busy_o,
  output rc_ode_pkg::ctrl_t ctrl_o
);
  import rc_ode_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              pass_q, pass_d;

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
          step_d  = '0;
          pass_d  = 1'b0;
        end
      end
      ST_RUN: begin
        if (step_q == STEP_LAST) begin
          step_d = '0;
          if (pass_q) begin
            state_d = ST_DONE;
          end else begin
            pass_d = 1'b1;
          end
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

  // Outputs: one pass of the derivative schedule, products overlap adds
  always_comb begin
    ctrl_o.mul_op   = MUL_NONE;
    ctrl_o.prod_dst = PD_NONE;
    ctrl_o.add_op   = ADD_NONE;
    ctrl_o.pass     = pass_q;
    ctrl_o.start    = 1'b0;
    ctrl_o.finish   = 1'b0;
    busy_o          = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: ctrl_o.start = in_valid_i;
      ST_RUN: begin
        unique case (step_q)
          4'd0: ctrl_o.mul_op = MUL_R3_X0;
          4'd1: begin
            ctrl_o.prod_dst = PD_DROP;
            ctrl_o.mul_op   = MUL_K2_X0;
          end
          4'd2: begin
            ctrl_o.prod_dst = PD_D1;
            ctrl_o.add_op   = ADD_SUM;
          end
          4'd3: begin
            ctrl_o.mul_op = MUL_G_SUM;
            ctrl_o.add_op = ADD_UPD1;
          end
          4'd4: ctrl_o.prod_dst = PD_A;
          4'd5: begin
            ctrl_o.mul_op = MUL_K1_A;
            ctrl_o.add_op = ADD_T;
          end
          4'd6: begin
            ctrl_o.prod_dst = PD_D0;
            ctrl_o.mul_op   = MUL_K3_T;
          end
          4'd7: begin
            ctrl_o.prod_dst = PD_D2;
            ctrl_o.add_op   = ADD_UPD0;
          end
          4'd8: ctrl_o.add_op = ADD_UPD2;
          default: ctrl_o.add_op = ADD_NONE;
        endcase
      end
      ST_DONE: ctrl_o.finish = out_free_i;
      default: ctrl_o.start = 1'b0;
    endcase
  end

endmodule

// ===== sv/rc_circuit_ode_step.sv =====
// Each transaction runs through the accept, two passes of nine steps through the single shared
// multiplier and saturating adder, and the result hand-off; no new one is taken until it ends.
// Input stalls for the whole step; a finished step also holds input off while the previous
// result is still stalled at the output.
// Reset (rst_ni low, asynchronous) loads the default coefficients and clears the
// loop current and both capacitor voltages.
module rc_circuit_ode_step (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rc_ode_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [rc_ode_pkg::CW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [rc_ode_pkg::DW-1:0]    source_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [rc_ode_pkg::DW-1:0]    output_voltage_o,
  output logic                                overflow_o
);
  import rc_ode_pkg::*;

  ctrl_t ctrl;
  logic  busy;
  logic  out_free;

  logic [CW-1:0] r3_q, g_q, k1_q, k2_q, k3_q;

  logic signed [DW-1:0] x_q [3];
  logic signed [DW-1:0] p_q [3];
  logic signed [DW-1:0] d_q [3];
  logic signed [DW-1:0] opnd [3];
  logic signed [DW-1:0] u_q, drop_q, sum_q, a_q, t_q;
  logic                 flag_q;

  logic                 out_valid_q;
  logic signed [DW-1:0] out_volt_q;
  logic                 out_ovf_q;

  logic [CW-1:0]        mul_coef;
  logic signed [DW-1:0] mul_val;
  logic signed [DW-1:0] add_a [4];
  logic [3:0]           add_neg;
  sat_t                 prod_res, add_res;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy;

  rc_ode_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  rc_ode_alu u_alu (
    .clk_i      (clk_i),
    .mul_coef_i (mul_coef),
    .mul_val_i  (mul_val),
    .add_a_i    (add_a),
    .add_neg_i  (add_neg),
    .prod_o     (prod_res),
    .add_o      (add_res)
  );

  // Derivative operands: state on the predictor pass, predictor on the corrector pass
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      opnd[k] = ctrl.pass ? p_q[k] : x_q[k];
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_coef = '0;
    mul_val  = '0;
    case (ctrl.mul_op)
      MUL_R3_X0: begin mul_coef = r3_q; mul_val = opnd[0]; end
      MUL_K2_X0: begin mul_coef = k2_q; mul_val = opnd[0]; end
      MUL_G_SUM: begin mul_coef = g_q;  mul_val = sum_q;   end
      MUL_K1_A:  begin mul_coef = k1_q; mul_val = a_q;     end
      MUL_K3_T:  begin mul_coef = k3_q; mul_val = t_q;     end
      default:   begin mul_coef = '0;   mul_val = '0;      end
    endcase
  end

  // Adder operand select
  always_comb begin
    add_a[0] = '0;
    add_a[1] = '0;
    add_a[2] = '0;
    add_a[3] = '0;
    add_neg  = 4'b0000;
    case (ctrl.add_op)
      ADD_SUM: begin
        // u - v2 - r3*i - v3
        add_a[0] = u_q;
        add_a[1] = opnd[1];
        add_a[2] = drop_q;
        add_a[3] = opnd[2];
        add_neg  = 4'b1110;
      end
      ADD_T: begin
        add_a[0] = a_q;
        add_a[1] = opnd[0];
        add_neg  = 4'b0010;
      end
      ADD_UPD0: begin add_a[0] = x_q[0]; add_a[1] = d_q[0]; end
      ADD_UPD1: begin add_a[0] = x_q[1]; add_a[1] = d_q[1]; end
      ADD_UPD2: begin add_a[0] = x_q[2]; add_a[1] = d_q[2]; end
      default:  add_neg = 4'b0000;
    endcase
  end

  // Coefficients, state, saturation flag and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r3_q        <= R3_RST;
      g_q         <= G_RST;
      k1_q        <= K1_RST;
      k2_q        <= K2_RST;
      k3_q        <= K3_RST;
      x_q[0]      <= '0;
      x_q[1]      <= '0;
      x_q[2]      <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SERIES_RES: r3_q <= cfg_data_i;
          CFG_LOOP_COND:  g_q  <= cfg_data_i;
          CFG_STEP_C1:    k1_q <= cfg_data_i;
          CFG_STEP_C2:    k2_q <= cfg_data_i;
          CFG_STEP_C3:    k3_q <= cfg_data_i;
          default:        r3_q <= r3_q;
        endcase
      end

      // corrector pass updates the state itself
      if (ctrl.pass) begin
        case (ctrl.add_op)
          ADD_UPD0: x_q[0] <= add_res.val;
          ADD_UPD1: x_q[1] <= add_res.val;
          ADD_UPD2: x_q[2] <= add_res.val;
          default:  x_q[0] <= x_q[0];
        endcase
      end

      if (ctrl.start) begin
        flag_q <= 1'b0;
      end else if (((ctrl.prod_dst != PD_NONE) && prod_res.ovf) ||
                   ((ctrl.add_op != ADD_NONE) && add_res.ovf)) begin
        flag_q <= 1'b1;
      end

      if (ctrl.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (ctrl.start) begin
      u_q <= source_sample_i;
    end

    case (ctrl.prod_dst)
      PD_DROP: drop_q   <= prod_res.val;
      PD_A:    a_q      <= prod_res.val;
      PD_D0:   d_q[0]   <= prod_res.val;
      PD_D1:   d_q[1]   <= prod_res.val;
      PD_D2:   d_q[2]   <= prod_res.val;
      default: drop_q   <= drop_q;
    endcase

    // predictor pass fills the predictor
    case (ctrl.add_op)
      ADD_SUM:  sum_q <= add_res.val;
      ADD_T:    t_q   <= add_res.val;
      ADD_UPD0: if (!ctrl.pass) p_q[0] <= add_res.val;
      ADD_UPD1: if (!ctrl.pass) p_q[1] <= add_res.val;
      ADD_UPD2: if (!ctrl.pass) p_q[2] <= add_res.val;
      default:  sum_q <= sum_q;
    endcase

    if (ctrl.finish) begin
      out_volt_q <= x_q[2];
      out_ovf_q  <= flag_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign output_voltage_o = out_volt_q;
  assign overflow_o       = out_ovf_q;

endmodule

// ===== test/tb_rc_circuit_ode_step.sv =====
module tb_rc_circuit_ode_step;
  import rc_ode_pkg::*;

  typedef logic signed [DW-1:0] q16_t;

  // Circuit state: loop current and the two capacitor voltages
  typedef struct packed {
    q16_t cur;
    q16_t v2;
    q16_t v3;
  } circuit_t;

  typedef struct packed {
    q16_t volt;
    logic ovf;
  } voltage_t;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam logic [CW-1:0] COEF_MAX     = {CW{1'b1}};
  localparam int          SWING          = 200 << FRAC_BITS;  // +/-200.0 V

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               cfg_we_i         = 1'b0;
  logic [IDX_W-1:0]   cfg_idx_i        = '0;
  logic [CW-1:0]      cfg_data_i       = '0;
  logic               in_valid_i       = 1'b0;
  logic               in_stall_o;
  q16_t               source_sample_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i      = 1'b0;
  q16_t               output_voltage_o;
  logic               overflow_o;

  rc_circuit_ode_step uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .source_sample_i  (source_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .output_voltage_o (output_voltage_o),
    .overflow_o       (overflow_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the coefficients and the circuit state
  logic [CW-1:0] coef [5];
  circuit_t      circ;
  bit            sat_hit;

  q16_t          sample_q  [$];
  voltage_t      voltage_q [$];

  int unsigned   err_cnt   = 0;
  int unsigned   quiet_cnt = 0;
  bit            no_idle   = 1'b0;
  logic          in_fire   = 1'b0;
  logic          out_fire  = 1'b0;
  int unsigned   gap_left  = 0;
  int unsigned   stall_left = 0;

  // Saturate to 32 bits, noting any clamp for this step
  function automatic q16_t clip(input longint v);
    if (v > 64'sd2147483647) begin
      sat_hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat_hit = 1'b1;
      return 32'sh8000_0000;
    end
    return q16_t'(v);
  endfunction

  // Coefficient times value, floor-scaled back to Q16.16
  function automatic q16_t scale(input logic [CW-1:0] k, input q16_t v);
    longint prod;
    prod = longint'({33'd0, k}) * longint'(v);
    return clip(prod >>> FRAC_BITS);
  endfunction

  function automatic circuit_t derivs(input q16_t u, input circuit_t x);
    circuit_t d;
    q16_t     drop;
    q16_t     sum;
    q16_t     a;
    drop  = scale(coef[CFG_SERIES_RES], x.cur);
    sum   = clip(longint'(u) - longint'(x.v2) - longint'(drop) - longint'(x.v3));
    a     = scale(coef[CFG_LOOP_COND], sum);
    d.cur = scale(coef[CFG_STEP_C1], a);
    d.v2  = scale(coef[CFG_STEP_C2], x.cur);
    d.v3  = scale(coef[CFG_STEP_C3], clip(longint'(a) - longint'(x.cur)));
    return d;
  endfunction

  function automatic circuit_t add_step(input circuit_t x, input circuit_t d);
    circuit_t r;
    r.cur = clip(longint'(x.cur) + longint'(d.cur));
    r.v2  = clip(longint'(x.v2) + longint'(d.v2));
    r.v3  = clip(longint'(x.v3) + longint'(d.v3));
    return r;
  endfunction

  // Predictor-corrector step; queues the expected output voltage
  function automatic void advance_circuit(input q16_t u);
    circuit_t pred;
    voltage_t want;
    sat_hit   = 1'b0;
    pred      = add_step(circ, derivs(u, circ));
    circ      = add_step(circ, derivs(u, pred));
    want.volt = circ.v3;
    want.ovf  = sat_hit;
    voltage_q = {voltage_q, want};
  endfunction

  // Append one sample to the pending stimulus
  function automatic void add_sample(input q16_t s);
    sample_q = {sample_q, s};
  endfunction

  // Source driver: one transaction at a time, random gap after each (none while no_idle is set)
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (sample_q.size() > 0) begin
          source_sample_i <= sample_q.pop_front();
          in_valid_i      <= 1'b1;
          gap_left        <= no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result sink back-pressure: random stall on each result while it is offered (none while no_idle is set)
  always @(negedge clk_i) begin
    int unsigned wait_n;
    if (rst_ni) begin
      wait_n = out_fire ? (no_idle ? 0 : $urandom_range(0, 3)) : stall_left;
      if (out_valid_o && wait_n > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= wait_n - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= wait_n;
      end
    end
  end

  // Monitor: predict on input transactions, check on output transactions
  always @(posedge clk_i) begin
    voltage_t want;
    if (rst_ni) begin
      in_fire  <= in_valid_i && !in_stall_o;
      out_fire <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o)
        advance_circuit(source_sample_i);
      if (out_valid_o && !out_stall_i) begin
        if (voltage_q.size() == 0) begin
          $error("output transaction with no expected result waiting");
          err_cnt++;
        end else begin
          want = voltage_q.pop_front();
          if (output_voltage_o !== want.volt) begin
            $error("output_voltage: expected %0d, got %0d", want.volt, output_voltage_o);
            err_cnt++;
          end
          if (overflow_o !== want.ovf) begin
            $error("overflow: expected %0b, got %0b", want.ovf, overflow_o);
            err_cnt++;
          end
        end
      end
      // watchdog on stalled progress
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cnt <= 0;
      else if (quiet_cnt >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else
        quiet_cnt <= quiet_cnt + 1;
    end
  end

  task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [CW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    // indexes past the last register must be ignored
    if (idx <= CFG_STEP_C3)
      coef[idx] = val;
  endtask

  task automatic end_write;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait on the rising edge, where the driven handshake is settled
  task automatic drain;
    while (sample_q.size() != 0 || voltage_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] pick_coef();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel) inside
      0:       return '0;
      1:       return COEF_MAX;
      2:       return CW'($urandom);
      [3:4]:   return CW'($urandom_range(0, 1 << 17));
      default: return CW'($urandom_range(0, 1 << 14));
    endcase
  endfunction

  function automatic q16_t pick_sample();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 16)
      return q16_t'($urandom_range(0, 2 * SWING)) - q16_t'(SWING);
    else if (sel < 19)
      return q16_t'($urandom);
    else
      return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  initial begin
    coef[CFG_SERIES_RES] = R3_RST;
    coef[CFG_LOOP_COND]  = G_RST;
    coef[CFG_STEP_C1]    = K1_RST;
    coef[CFG_STEP_C2]    = K2_RST;
    coef[CFG_STEP_C3]    = K3_RST;
    circ = '0;

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: sample extremes with reset coefficients
    add_sample(32'sd0);
    add_sample(32'sd1);
    add_sample(-32'sd1);
    add_sample(32'sh0001_0000);
    add_sample(-32'sh0001_0000);
    add_sample(32'sh0064_0000);
    add_sample(32'sh7FFF_FFFF);
    add_sample(32'sh7FFF_FFFF);
    add_sample(32'sh8000_0000);
    add_sample(32'sh8000_0000);
    add_sample(32'sh5555_5555);
    add_sample(32'shAAAA_AAAA);
    drain();

    // Directed: all coefficients at full scale, forcing saturation
    for (int r = CFG_SERIES_RES; r <= CFG_STEP_C3; r++)
      write_coef(IDX_W'(r), COEF_MAX);
    write_coef(IDX_W'(CFG_STEP_C3) + 3'd1, '0);
    end_write();
    add_sample(32'sh7FFF_FFFF);
    add_sample(32'sh8000_0000);
    add_sample(32'sd0);
    add_sample(32'sh0001_0000);
    drain();

    // Directed: all coefficients zero, state must hold
    for (int r = CFG_SERIES_RES; r <= CFG_STEP_C3; r++)
      write_coef(IDX_W'(r), '0);
    write_coef(3'd7, COEF_MAX);
    end_write();
    add_sample(32'sh8000_0000);
    add_sample(32'sh7FFF_FFFF);
    add_sample(32'sd12345);
    drain();

    // Random phases with fresh coefficients each
    for (int ph = 0; ph < 10; ph++) begin
      for (int r = CFG_SERIES_RES; r <= CFG_STEP_C3; r++)
        write_coef(IDX_W'(r), pick_coef());
      if ($urandom_range(0, 1) != 0)
        write_coef(IDX_W'(CFG_STEP_C3) + IDX_W'($urandom_range(1, 3)), CW'($urandom));
      end_write();
      no_idle = (ph % 3 == 2);
      for (int n = 0; n < 85; n++)
        add_sample(pick_sample());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
